// ===== rtl/pse_pkg.sv =====
// Shared types, symbol codes and status codes for the postfix stack evaluator.
`default_nettype none
package pse_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;
	localparam logic [7:0] SYM_MOD  = 8'h25;
	localparam logic [7:0] SYM_POW  = 8'h5E;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_DIVZERO   = 3'd3;
	localparam logic [2:0] ST_BADSYM    = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW
	} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        div_zero;
		logic [31:0] result;
	} alu_rsp_t;

	function automatic logic is_digit(logic [7:0] s);
		return (s >= SYM_ZERO) && (s <= SYM_NINE);
	endfunction

	function automatic logic is_oper(logic [7:0] s);
		return (s == SYM_ADD) || (s == SYM_SUB) || (s == SYM_MUL) ||
			(s == SYM_DIV) || (s == SYM_MOD) || (s == SYM_POW);
	endfunction

	function automatic alu_op_t sym_to_op(logic [7:0] s);
		alu_op_t op;
		case (s)
			SYM_ADD: op = OP_ADD;
			SYM_SUB: op = OP_SUB;
			SYM_MUL: op = OP_MUL;
			SYM_DIV: op = OP_DIV;
			SYM_MOD: op = OP_MOD;
			SYM_POW: op = OP_POW;
			default: op = OP_ADD;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pse_stack.sv =====
// Operand stack memory: one write port and one read port with registered read data.
`default_nettype none
module pse_stack #(
	parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [31:0]   wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pse_alu.sv =====
// Iterative arithmetic unit: one adder path, one shared multiplier and a bit-serial divider.
`default_nettype none
module pse_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pse_pkg::alu_req_t req,
	output pse_pkg::alu_rsp_t      rsp
);

	typedef enum logic [2:0] {
		A_IDLE,
		A_DIV,
		A_DFIX,
		A_PMUL,
		A_PSQ,
		A_DONE
	} alu_state_t;

	alu_state_t       state_q;
	pse_pkg::alu_op_t op_q;
	logic [31:0]      acc_q;
	logic [31:0]      sq_q;
	logic [31:0]      exp_q;
	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      dvs_q;
	logic [4:0]       cnt_q;
	logic             qneg_q;
	logic             rneg_q;
	logic [31:0]      res_q;
	logic             dz_q;

	logic [31:0] a_mag;
	logic [31:0] b_mag;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [31:0] mul_p;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic [31:0] pow_neg;

	assign a_mag = req.a[31] ? (32'd0 - req.a) : req.a;
	assign b_mag = req.b[31] ? (32'd0 - req.b) : req.b;

	// The single multiplier serves the plain product and both steps of square-and-multiply.
	always_comb begin
		case (state_q)
			A_PMUL: begin
				mul_x = acc_q;
				mul_y = sq_q;
			end
			A_PSQ: begin
				mul_x = sq_q;
				mul_y = sq_q;
			end
			default: begin
				mul_x = req.a;
				mul_y = req.b;
			end
		endcase
	end

	assign mul_p   = mul_x * mul_y;
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};

	// A negative exponent only survives for a base of one or minus one.
	always_comb begin
		if (req.a == 32'd1) begin
			pow_neg = 32'd1;
		end else if (req.a == 32'hFFFF_FFFF) begin
			pow_neg = req.b[0] ? 32'hFFFF_FFFF : 32'd1;
		end else begin
			pow_neg = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						dz_q <= 1'b0;
						case (req.op)
							pse_pkg::OP_ADD: begin
								res_q   <= req.a + req.b;
								state_q <= A_DONE;
							end
							pse_pkg::OP_SUB: begin
								res_q   <= req.a - req.b;
								state_q <= A_DONE;
							end
							pse_pkg::OP_MUL: begin
								res_q   <= mul_p;
								state_q <= A_DONE;
							end
							pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
								if (req.b == 32'd0) begin
									dz_q    <= 1'b1;
									res_q   <= 32'd0;
									state_q <= A_DONE;
								end else begin
									rem_q   <= 32'd0;
									quo_q   <= a_mag;
									dvs_q   <= b_mag;
									cnt_q   <= 5'd0;
									qneg_q  <= req.a[31] ^ req.b[31];
									rneg_q  <= req.a[31];
									state_q <= A_DIV;
								end
							end
							pse_pkg::OP_POW: begin
								if (req.b[31]) begin
									res_q   <= pow_neg;
									state_q <= A_DONE;
								end else if (req.b == 32'd0) begin
									res_q   <= 32'd1;
									state_q <= A_DONE;
								end else begin
									acc_q   <= 32'd1;
									sq_q    <= req.a;
									exp_q   <= req.b;
									state_q <= A_PMUL;
								end
							end
							default: begin
								res_q   <= 32'd0;
								state_q <= A_DONE;
							end
						endcase
					end
				end
				A_DIV: begin
					// Restoring division on magnitudes, one quotient bit per cycle.
					if (!diff[32]) begin
						rem_q <= diff[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= shifted[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= A_DFIX;
					end
				end
				A_DFIX: begin
					if (op_q == pse_pkg::OP_DIV) begin
						res_q <= qneg_q ? (32'd0 - quo_q) : quo_q;
					end else begin
						res_q <= rneg_q ? (32'd0 - rem_q) : rem_q;
					end
					state_q <= A_DONE;
				end
				A_PMUL: begin
					if (exp_q[0]) begin
						acc_q <= mul_p;
					end
					state_q <= A_PSQ;
				end
				A_PSQ: begin
					sq_q  <= mul_p;
					exp_q <= {1'b0, exp_q[31:1]};
					if (exp_q[31:1] == 31'd0) begin
						res_q   <= acc_q;
						state_q <= A_DONE;
					end else begin
						state_q <= A_PMUL;
					end
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done     = (state_q == A_DONE);
	assign rsp.div_zero = dz_q;
	assign rsp.result   = res_q;

endmodule
`default_nettype wire

// ===== rtl/postfix_stack_evaluator_unit.sv =====
// Top level of the postfix stack evaluator: token sequencer, stack control and result register.
//
// Tokens arrive on the token channel (token_valid, token_stall, symbol, last), one byte
// per transfer. A digit pushes 0..9; + - * / % ^ pop two operands and push the result.
// The transfer that carries last produces one result on the result channel (result_valid,
// result_stall, value, status) after the token itself is processed.
// The block takes one token at a time and holds token_stall high while it works on it.
// A digit is pushed in the decode step. An operator reads both operands and then waits
// on the arithmetic unit: divide and remainder produce one quotient bit per cycle, and
// power uses square-and-multiply over one shared multiplier, one multiply step and
// one square step per exponent bit. A last token then reads the top of the stack.
// The result sits in an output register; further tokens are taken while it waits, and
// only the next last token waits in its final step until the register is free.
// Errors are sticky within one expression; the stack and the error clear after each
// result. Reset empties the stack, clears the error and drops result_valid. The stack
// memory needs no clearing pass since only entries below the fill count are ever used.
`default_nettype none
module postfix_stack_evaluator_unit #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               token_valid,
	output logic                    token_stall,
	input  wire logic [7:0]         symbol,
	input  wire logic               last,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      value,
	output logic        [2:0]       status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_FIN_RD,
		S_FIN_OUT
	} seq_state_t;

	seq_state_t  state_q;
	logic [7:0]  sym_q;
	logic        last_q;
	logic [CW-1:0] count_q;
	logic [2:0]  error_q;
	logic [31:0] b_q;
	logic        res_valid_q;
	logic [31:0] value_q;
	logic [2:0]  status_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          sym_digit;
	logic          sym_oper;
	logic          out_free;

	pse_pkg::alu_req_t alu_req;
	pse_pkg::alu_rsp_t alu_rsp;

	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign sym_digit = pse_pkg::is_digit(sym_q);
	assign sym_oper  = pse_pkg::is_oper(sym_q);
	assign out_free  = !res_valid_q || !result_stall;

	// A push writes at the fill count; an operator result replaces the lower operand.
	assign wr_en = ((state_q == S_DECODE) && (error_q == pse_pkg::ST_OK) && sym_digit &&
			(count_q != CW'(STACK_DEPTH))) ||
		((state_q == S_EXEC) && alu_rsp.done && !alu_rsp.div_zero);
	assign wr_addr = (state_q == S_DECODE) ? count_q[AW-1:0] : cnt_m2[AW-1:0];
	assign wr_data = (state_q == S_DECODE) ? 32'(sym_q - pse_pkg::SYM_ZERO) : alu_rsp.result;

	assign rd_en = ((state_q == S_DECODE) && (error_q == pse_pkg::ST_OK) && sym_oper &&
			(count_q >= CW'(2))) ||
		(state_q == S_RD_B) || (state_q == S_FIN_RD);
	assign rd_addr = (state_q == S_RD_B) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

	assign alu_req.start = (state_q == S_RD_A);
	assign alu_req.op    = pse_pkg::sym_to_op(sym_q);
	assign alu_req.a     = rd_data;
	assign alu_req.b     = b_q;

	pse_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			error_q     <= pse_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			// The final step loads the next result itself when the register frees up.
			if (res_valid_q && !result_stall && (state_q != S_FIN_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (token_valid) begin
						sym_q   <= symbol;
						last_q  <= last;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (error_q != pse_pkg::ST_OK) begin
						state_q <= last_q ? S_FIN_RD : S_IDLE;
					end else if (sym_digit) begin
						if (count_q == CW'(STACK_DEPTH)) begin
							error_q <= pse_pkg::ST_OVERFLOW;
						end else begin
							count_q <= count_q + CW'(1);
						end
						state_q <= last_q ? S_FIN_RD : S_IDLE;
					end else if (sym_oper) begin
						if (count_q < CW'(2)) begin
							error_q <= pse_pkg::ST_UNDERFLOW;
							state_q <= last_q ? S_FIN_RD : S_IDLE;
						end else begin
							state_q <= S_RD_B;
						end
					end else begin
						error_q <= pse_pkg::ST_BADSYM;
						state_q <= last_q ? S_FIN_RD : S_IDLE;
					end
				end
				S_RD_B: begin
					b_q     <= rd_data;
					state_q <= S_RD_A;
				end
				S_RD_A: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						if (alu_rsp.div_zero) begin
							error_q <= pse_pkg::ST_DIVZERO;
						end else begin
							count_q <= cnt_m1;
						end
						state_q <= last_q ? S_FIN_RD : S_IDLE;
					end
				end
				S_FIN_RD: begin
					state_q <= S_FIN_OUT;
				end
				S_FIN_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						if (error_q != pse_pkg::ST_OK) begin
							status_q <= error_q;
							value_q  <= 32'd0;
						end else if (count_q == '0) begin
							status_q <= pse_pkg::ST_EMPTY;
							value_q  <= 32'd0;
						end else begin
							status_q <= pse_pkg::ST_OK;
							value_q  <= rd_data;
						end
						count_q <= '0;
						error_q <= pse_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign token_stall  = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign value        = $signed(value_q);
	assign status       = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack fill count exceeds depth");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_FIN_OUT))
		else $error("result raised outside the final step");

	a_alu_owner: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_EXEC))
		else $error("arithmetic unit finished while sequencer was not waiting");

	a_error_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status != pse_pkg::ST_OK)) |-> (value == 32'sd0))
		else $error("nonzero value returned with an error status");
`endif

endmodule
`default_nettype wire
